/* rtl/fdsa_pkg.sv */
// Package for the Forth data stack ALU: operation codes, error codes,
// controller-to-datapath command struct. No dependencies.
package fdsa_pkg;
    localparam logic [4:0] OP_PUSH = 5'd0,  OP_ADD = 5'd1,  OP_SUB = 5'd2,  OP_MUL = 5'd3;
    localparam logic [4:0] OP_DIV  = 5'd4,  OP_LT  = 5'd5,  OP_GT  = 5'd6,  OP_EQ  = 5'd7;
    localparam logic [4:0] OP_NE   = 5'd8,  OP_LE  = 5'd9,  OP_GE  = 5'd10, OP_ZLT = 5'd11;
    localparam logic [4:0] OP_ZGT  = 5'd12, OP_ZEQ = 5'd13, OP_ZNE = 5'd14, OP_ZLE = 5'd15;
    localparam logic [4:0] OP_ZGE  = 5'd16, OP_AND = 5'd17, OP_OR  = 5'd18, OP_XOR = 5'd19;
    localparam logic [4:0] OP_SWAP = 5'd20, OP_DUP = 5'd21, OP_DROP = 5'd22, OP_OVER = 5'd23;
    localparam logic [4:0] OP_ROT  = 5'd24, OP_PICK = 5'd25, OP_POP = 5'd26;

    localparam logic [1:0] ERR_NONE = 2'd0, ERR_UNDER = 2'd1, ERR_OVER = 2'd2, ERR_DIVZ = 2'd3;

    // Datapath register select codes
    localparam logic [1:0] SEL_B = 2'd0, SEL_A = 2'd1, SEL_C = 2'd2;

    typedef struct packed {
        logic       rd_en;     // issue memory read
        logic [1:0] rd_off;    // read at sp-1-rd_off (when rd_pick is low)
        logic       rd_pick;   // use pick address
        logic [1:0] ld_sel;    // which operand register loads the RAM read data
        logic       ld_en;
        logic       start_mul;
        logic       start_div;
    } t_cmd;
endpackage

/* rtl/fdsa_ram.sv */
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module fdsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

/* rtl/fdsa_muldiv.sv */
// Iterative multiply (shift-add) and signed divide (restoring), one bit a cycle.
// Depends on nothing outside this file.
module fdsa_muldiv #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start_mul,
    input  logic         i_start_div,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_done,
    output logic [W-1:0] o_result
);
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done, r_is_div, r_neg;
    logic [W-1:0]  r_acc, r_x, r_y, r_rem;
    logic [W:0]    w_trial;

    assign w_trial = {r_rem, r_x[W-1]} - {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start_mul || i_start_div) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start_mul) begin
            r_is_div <= 1'b0;
            r_acc    <= '0;
            r_x      <= i_a;
            r_y      <= i_b;
        end else if (i_start_div) begin
            r_is_div <= 1'b1;
            r_neg    <= i_a[W-1] ^ i_b[W-1];
            r_x      <= i_a[W-1] ? -i_a : i_a;
            r_y      <= i_b[W-1] ? -i_b : i_b;
            r_rem    <= '0;
        end else if (r_busy) begin
            if (!r_is_div) begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= r_x << 1;
                r_y <= r_y >> 1;
            end else if (!w_trial[W]) begin
                r_rem <= w_trial[W-1:0];
                r_x   <= {r_x[W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[W-2:0], r_x[W-1]};
                r_x   <= {r_x[W-2:0], 1'b0};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_is_div ? (r_neg ? -r_x : r_x) : r_acc;
endmodule

/* rtl/fdsa_ctrl.sv */
// Controller: sequences reads of the stack memory and the iterative unit.
// Depends on fdsa_pkg.
module fdsa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [4:0]           i_op,
    input  logic                 i_ok,        // operation legal (no error)
    input  logic                 i_unit_done,
    input  logic                 i_out_free,  // result register can take a word
    output fdsa_pkg::t_cmd       o_cmd,
    output logic                 o_idle,
    output logic                 o_finish
);
    import fdsa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_RD1 = 3'd1, S_RD2 = 3'd2, S_RD3 = 3'd3;
    localparam logic [2:0] S_PICK = 3'd4, S_UNIT = 3'd5, S_FIN = 3'd6, S_WAIT = 3'd7;

    logic [2:0] r_state, n_state;
    logic [4:0] r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (i_start) begin
            r_op <= i_op;
        end
    end

    // Reads: RD1 issues top (b), RD2 a, RD3 c; each lands in the next cycle.
    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_off = 2'd0;
                n_state = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_off = 2'd1;
                o_cmd.ld_en = 1'b1; o_cmd.ld_sel = SEL_B;
                n_state = S_RD3;
            end
            S_RD3: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_off = 2'd2;
                o_cmd.ld_en = 1'b1; o_cmd.ld_sel = SEL_A;
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_pick = 1'b1;
                o_cmd.ld_en = 1'b1; o_cmd.ld_sel = SEL_C;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                // pick result lands in the c register
                o_cmd.ld_en = (r_op == OP_PICK); o_cmd.ld_sel = SEL_C;
                if (i_ok && (r_op == OP_MUL || r_op == OP_DIV)) begin
                    o_cmd.start_mul = (r_op == OP_MUL);
                    o_cmd.start_div = (r_op == OP_DIV);
                    n_state = S_UNIT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_UNIT: begin
                if (i_unit_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold the writeback while the previous result still waits
                if (i_out_free) begin
                    o_finish = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);
endmodule

/* rtl/fdsa_dp.sv */
// Datapath: stack memory, pointer, operand registers, ALU and writeback.
// Depends on fdsa_pkg, fdsa_ram, fdsa_muldiv.
module fdsa_dp #(
    parameter int STACK_DEPTH = 64,
    parameter int CELL_WIDTH  = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [4:0]         i_op,
    input  logic [63:0]        i_lit,
    input  fdsa_pkg::t_cmd     i_cmd,
    input  logic               i_finish,
    output logic               o_ok,
    output logic               o_unit_done,
    output logic [63:0]        o_top,
    output logic [63:0]        o_removed,
    output logic [6:0]         o_count,
    output logic [1:0]         o_err
);
    import fdsa_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int W  = CELL_WIDTH;

    logic [PW-1:0] r_sp, r_cnt;
    logic [4:0]    r_op;
    logic [W-1:0]  r_lit, r_a, r_b, r_c, r_top, r_rem;
    logic [W-1:0]  w_rdata, w_mres, w_res, w_wdata;
    logic [AW-1:0] w_raddr, w_waddr;
    logic [PW-1:0] n_sp, w_pidx;
    logic          w_we, w_neg, w_lt, w_gt, w_eq, w_c;
    logic [1:0]    w_err, r_err;
    logic          r_wr2;      // second write pending (swap, rot)
    logic          r_wr3;      // third write pending (rot)
    logic [AW-1:0] r_w2addr;
    logic [W-1:0]  r_w2data;

    fdsa_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    fdsa_muldiv #(.W(W)) u_md (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start_mul(i_cmd.start_mul), .i_start_div(i_cmd.start_div),
        .i_a(r_a), .i_b(r_b), .o_done(o_unit_done), .o_result(w_mres)
    );

    // pick reads at sp-2-u; only legal when u < sp-1, checked in o_ok
    assign w_pidx  = r_sp - PW'(2) - PW'(r_b[PW-1:0]);
    assign w_raddr = i_cmd.rd_pick ? w_pidx[AW-1:0]
                                   : AW'(r_sp - PW'(1) - PW'(i_cmd.rd_off));

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_op;
            r_lit <= i_lit[W-1:0];
        end
        if (i_cmd.ld_en) begin
            case (i_cmd.ld_sel)
                SEL_B:   r_b <= w_rdata;
                SEL_A:   r_a <= w_rdata;
                default: r_c <= w_rdata;
            endcase
        end
    end

    assign w_neg  = r_b[W-1];
    assign w_lt   = $signed(r_a) < $signed(r_b);
    assign w_gt   = $signed(r_b) < $signed(r_a);
    assign w_eq   = (r_a == r_b);

    // error and legality
    always_comb begin
        w_err = ERR_NONE;
        case (r_op)
            OP_PUSH: if (r_sp >= PW'(STACK_DEPTH)) w_err = ERR_OVER;
            OP_DUP:  if (r_sp < PW'(1)) w_err = ERR_UNDER;
                     else if (r_sp >= PW'(STACK_DEPTH)) w_err = ERR_OVER;
            OP_OVER: if (r_sp < PW'(2)) w_err = ERR_UNDER;
                     else if (r_sp >= PW'(STACK_DEPTH)) w_err = ERR_OVER;
            OP_DIV:  if (r_sp < PW'(2)) w_err = ERR_UNDER;
                     else if (r_b == '0) w_err = ERR_DIVZ;
            OP_ZLT, OP_ZGT, OP_ZEQ, OP_ZNE, OP_ZLE, OP_ZGE, OP_DROP, OP_POP:
                     if (r_sp < PW'(1)) w_err = ERR_UNDER;
            OP_ROT:  if (r_sp < PW'(3)) w_err = ERR_UNDER;
            OP_PICK: if (r_sp < PW'(1) || r_b[W-1] ||
                         r_b >= W'(r_sp - PW'(1))) w_err = ERR_UNDER;
            default: if (r_op <= OP_XOR || r_op == OP_SWAP)
                         if (r_sp < PW'(2)) w_err = ERR_UNDER;
        endcase
    end
    assign o_ok = (w_err == ERR_NONE);

    // zero compares run on the top cell held in r_b
    always_comb begin
        case (r_op)
            OP_ZLT:  w_c = w_neg;
            OP_ZGT:  w_c = !w_neg && (r_b != '0);
            OP_ZEQ:  w_c = (r_b == '0);
            OP_ZNE:  w_c = (r_b != '0);
            OP_ZLE:  w_c = w_neg || (r_b == '0);
            default: w_c = !w_neg;
        endcase
    end

    always_comb begin
        case (r_op)
            OP_ADD:  w_res = r_a + r_b;
            OP_SUB:  w_res = r_a - r_b;
            OP_MUL, OP_DIV: w_res = w_mres;
            OP_LT:   w_res = {W{w_lt}};
            OP_GT:   w_res = {W{w_gt}};
            OP_EQ:   w_res = {W{w_eq}};
            OP_NE:   w_res = {W{!w_eq}};
            OP_LE:   w_res = {W{!w_gt}};
            OP_GE:   w_res = {W{!w_lt}};
            OP_AND:  w_res = r_a & r_b;
            OP_OR:   w_res = r_a | r_b;
            OP_XOR:  w_res = r_a ^ r_b;
            default: w_res = {W{w_c}};
        endcase
    end

    // final writeback at finish; swap and rot finish their writes in the
    // following cycles (rot: sp-1 <- old c, sp-2 <- old b, sp-3 <- old a)
    always_comb begin
        w_we    = 1'b0;
        w_waddr = AW'(r_sp - PW'(1));
        w_wdata = w_res;
        n_sp    = r_sp;
        if (r_wr2) begin
            w_we = 1'b1; w_waddr = r_w2addr; w_wdata = r_w2data;
        end else if (r_wr3) begin
            w_we = 1'b1; w_waddr = AW'(r_sp - PW'(3)); w_wdata = r_a;
        end else if (i_finish && o_ok) begin
            case (r_op)
                OP_PUSH: begin
                    w_we = 1'b1; w_waddr = r_sp[AW-1:0]; w_wdata = r_lit; n_sp = r_sp + 1'b1;
                end
                OP_DUP, OP_OVER: begin
                    w_we = 1'b1; w_waddr = r_sp[AW-1:0];
                    w_wdata = (r_op == OP_DUP) ? r_b : r_a; n_sp = r_sp + 1'b1;
                end
                OP_DROP, OP_POP: n_sp = r_sp - 1'b1;
                OP_SWAP: begin w_we = 1'b1; w_wdata = r_a; end
                OP_ROT:  begin w_we = 1'b1; w_wdata = r_c; end
                OP_PICK: begin w_we = 1'b1; w_wdata = r_c; end
                OP_ZLT, OP_ZGT, OP_ZEQ, OP_ZNE, OP_ZLE, OP_ZGE: w_we = 1'b1;
                default: begin
                    if (r_op <= OP_XOR && r_op != OP_PUSH) begin
                        w_we = 1'b1; w_waddr = AW'(r_sp - PW'(2)); n_sp = r_sp - 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp  <= '0;
            r_wr2 <= 1'b0;
            r_wr3 <= 1'b0;
        end else begin
            r_sp  <= n_sp;
            r_wr2 <= i_finish && o_ok && (r_op == OP_SWAP || r_op == OP_ROT);
            r_wr3 <= r_wr2 && (r_op == OP_ROT);
        end
        // sp-2 gets the old top for both swap and rot
        if (i_finish) begin
            r_w2addr <= AW'(r_sp - PW'(2));
            r_w2data <= r_b;
        end
        if (i_finish) begin
            // new top value
            case (r_op)
                OP_PUSH: r_top <= o_ok ? r_lit : r_b;
                OP_DUP:  r_top <= o_ok ? r_b : r_b;
                OP_OVER: r_top <= o_ok ? r_a : r_b;
                OP_DROP, OP_POP: r_top <= r_a;
                OP_SWAP: r_top <= o_ok ? r_a : r_b;
                OP_ROT, OP_PICK: r_top <= o_ok ? r_c : r_b;
                default: r_top <= (o_ok && r_op <= OP_ZGE && r_op != OP_PUSH) ? w_res :
                                  (o_ok && r_op <= OP_XOR) ? w_res : r_b;
            endcase
            r_err  <= w_err;
            r_rem  <= (o_ok && r_op == OP_POP) ? r_b : '0;
            r_cnt  <= n_sp;
        end
    end

    assign o_top     = (r_cnt == '0) ? 64'd0 : 64'(signed'(r_top));
    assign o_removed = 64'(signed'(r_rem));
    assign o_count   = 7'(r_cnt);
    assign o_err     = r_err;
endmodule

/* rtl/forth_data_stack_alu.sv */
// Forth data stack with an integer ALU; one word in, one result word out.
// Every word steps through the states RD1, RD2, RD3, PICK, WAIT and FIN;
// legal mul/div also pass UNIT (the bit-serial unit). One word in flight;
// a new word is taken while the previous result waits, and its writeback
// holds until that result leaves. Operand reads share the single RAM read
// port. Reset (synchronous): stack empty.
module forth_data_stack_alu #(
    parameter int STACK_DEPTH = 64,
    parameter int CELL_WIDTH  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_operation,
    input  logic [63:0] i_literal_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_top_value,
    output logic [63:0] o_removed_value,
    output logic [6:0]  o_stack_count,
    output logic [1:0]  o_error_code
);
    import fdsa_pkg::*;

    t_cmd       w_cmd;
    logic       w_idle, w_out_free;
    logic       w_start, w_ok, w_done, w_finish, r_valid;

    // Accept a new word whenever the controller is idle.
    assign o_ready = w_idle;
    assign w_start = i_valid && o_ready;
    // The result register is free when empty or being taken this cycle.
    assign w_out_free = !r_valid || i_ready;

    fdsa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_op(i_operation),
        .i_ok(w_ok), .i_unit_done(w_done), .i_out_free(w_out_free), .o_cmd(w_cmd),
        .o_idle(w_idle), .o_finish(w_finish)
    );

    fdsa_dp #(.STACK_DEPTH(STACK_DEPTH), .CELL_WIDTH(CELL_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_op(i_operation),
        .i_lit(i_literal_value), .i_cmd(w_cmd), .i_finish(w_finish), .o_ok(w_ok),
        .o_unit_done(w_done), .o_top(o_top_value), .o_removed(o_removed_value),
        .o_count(o_stack_count), .o_err(o_error_code)
    );

    // Hold the result valid until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_finish) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end
    assign o_valid = r_valid;
endmodule

/* rtl/fdsa_checker.sv */
// Port-level checker for the Forth stack ALU, bound to the top level.
// Depends on fdsa_pkg.
module fdsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_top_value,
    input logic [6:0]  o_stack_count,
    input logic [1:0]  o_error_code,
    input logic [63:0] o_removed_value
);
    import fdsa_pkg::*;

    // Result word holds its fields while it waits.
    a_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_top_value) && $stable(o_removed_value) &&
        $stable(o_error_code)) else $error("payload changed while waiting");
    // Result stays until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_stack_count))
        else $error("result dropped");
    // An error leaves no removed value.
    a_err_rm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != ERR_NONE |-> o_removed_value == 64'd0)
        else $error("removed on error");
    // Count never exceeds 64.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stack_count <= 7'd64) else $error("count range");
endmodule

bind forth_data_stack_alu fdsa_checker u_fdsa_checker (.*);

/* dv/tb.sv */
// Testbench for forth_data_stack_alu: drives operation words, predicts each
// result with a local stack model and checks every result word field by field.
// Depends on fdsa_pkg and the forth_data_stack_alu RTL.
module tb;
    import fdsa_pkg::*;

    localparam int DEPTH = 64;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [4:0]  i_operation = '0;
    logic [63:0] i_literal_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_top_value;
    logic [63:0] o_removed_value;
    logic [6:0]  o_stack_count;
    logic [1:0]  o_error_code;

    typedef struct packed {
        logic [63:0] top;
        logic [63:0] removed;
        logic [6:0]  count;
        logic [1:0]  err;
    } t_result;

    // Local copy of the stack; only entries below cell_count are read.
    logic [63:0] cells [DEPTH];
    int          cell_count = 0;
    t_result     pending_results [$];
    int          error_total = 0;
    bit          idle_enable = 1'b1;
    int          hold_cycles = 0;

    forth_data_stack_alu uut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] truth(input bit c);
        return c ? '1 : '0;
    endfunction

    // Apply one operation to the local stack and return its result word.
    function automatic t_result apply_op(input logic [4:0] op, input logic [63:0] lit);
        t_result     r;
        logic [63:0] a, b, t, q, ua, ub;
        logic [1:0]  e;
        logic [63:0] rem;
        int          sp;
        sp = cell_count;
        e = ERR_NONE;
        rem = '0;
        if (op == OP_PUSH) begin
            if (sp >= DEPTH) e = ERR_OVER;
            else begin cells[sp] = lit; sp++; end
        end else if (op <= OP_GE || (op >= OP_AND && op <= OP_XOR)) begin
            if (sp < 2) e = ERR_UNDER;
            else begin
                b = cells[sp-1];
                a = cells[sp-2];
                t = '0;
                case (op)
                    OP_ADD: t = a + b;
                    OP_SUB: t = a - b;
                    OP_MUL: t = a * b;
                    OP_DIV: begin
                        if (b == 0) e = ERR_DIVZ;
                        else begin
                            ua = a[63] ? -a : a;
                            ub = b[63] ? -b : b;
                            q = ua / ub;
                            t = (a[63] != b[63]) ? -q : q;
                        end
                    end
                    OP_LT: t = truth($signed(a) < $signed(b));
                    OP_GT: t = truth($signed(a) > $signed(b));
                    OP_EQ: t = truth(a == b);
                    OP_NE: t = truth(a != b);
                    OP_LE: t = truth($signed(a) <= $signed(b));
                    OP_GE: t = truth($signed(a) >= $signed(b));
                    OP_AND: t = a & b;
                    OP_OR: t = a | b;
                    default: t = a ^ b;
                endcase
                if (e == ERR_NONE) begin cells[sp-2] = t; sp--; end
            end
        end else if (op <= OP_ZGE) begin
            if (sp < 1) e = ERR_UNDER;
            else begin
                a = cells[sp-1];
                case (op)
                    OP_ZLT: t = truth(a[63]);
                    OP_ZGT: t = truth(!a[63] && a != 0);
                    OP_ZEQ: t = truth(a == 0);
                    OP_ZNE: t = truth(a != 0);
                    OP_ZLE: t = truth(a[63] || a == 0);
                    default: t = truth(!a[63]);
                endcase
                cells[sp-1] = t;
            end
        end else if (op == OP_SWAP) begin
            if (sp < 2) e = ERR_UNDER;
            else begin
                t = cells[sp-1]; cells[sp-1] = cells[sp-2]; cells[sp-2] = t;
            end
        end else if (op == OP_DUP || op == OP_OVER) begin
            if (sp < ((op == OP_DUP) ? 1 : 2)) e = ERR_UNDER;
            else if (sp >= DEPTH) e = ERR_OVER;
            else begin
                cells[sp] = cells[sp - ((op == OP_DUP) ? 1 : 2)];
                sp++;
            end
        end else if (op == OP_DROP) begin
            if (sp < 1) e = ERR_UNDER;
            else sp--;
        end else if (op == OP_ROT) begin
            if (sp < 3) e = ERR_UNDER;
            else begin
                t = cells[sp-3];
                cells[sp-3] = cells[sp-2];
                cells[sp-2] = cells[sp-1];
                cells[sp-1] = t;
            end
        end else if (op == OP_PICK) begin
            if (sp < 1) e = ERR_UNDER;
            else begin
                a = cells[sp-1];
                if (a[63] || a >= 64'(sp - 1)) e = ERR_UNDER;
                else cells[sp-1] = cells[sp - 2 - int'(a)];
            end
        end else if (op == OP_POP) begin
            if (sp < 1) e = ERR_UNDER;
            else begin sp--; rem = cells[sp]; end
        end
        cell_count = sp;
        r.top = (sp > 0) ? cells[sp-1] : '0;
        r.removed = rem;
        r.count = 7'(sp);
        r.err = e;
        return r;
    endfunction

    // Send one word; the prediction is queued at acceptance. Valid stays high
    // between back-to-back words and drops only for an idle burst.
    task automatic send_word(input logic [4:0] op, input logic [63:0] lit);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_literal_value <= lit;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(apply_op(op, lit));
    endtask

    // Receiver: random stalls, a long hold-off when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else if (idle_enable) i_ready <= ($urandom_range(0, 3) != 0);
        else i_ready <= 1'b1;
    end

    // Check each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result top=%h", $time, o_top_value);
                error_total++;
            end else begin
                want = pending_results.pop_front();
                if (o_top_value !== want.top) begin
                    $display("%0t: top exp %h got %h", $time, want.top, o_top_value);
                    error_total++;
                end
                if (o_removed_value !== want.removed) begin
                    $display("%0t: removed exp %h got %h", $time, want.removed,
                             o_removed_value);
                    error_total++;
                end
                if (o_stack_count !== want.count) begin
                    $display("%0t: count exp %0d got %0d", $time, want.count,
                             o_stack_count);
                    error_total++;
                end
                if (o_error_code !== want.err) begin
                    $display("%0t: error exp %0d got %0d", $time, want.err,
                             o_error_code);
                    error_total++;
                end
            end
        end
    end

    function automatic logic [63:0] rand_cell();
        case ($urandom_range(0, 7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return '1;
            3: return '0;
            4: return 64'($urandom_range(0, 8));
            5: return -64'($urandom_range(1, 8));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_directed();
        logic [4:0] op;
        send_word(OP_ADD, '0);        // underflow on empty stack
        send_word(OP_POP, '0);
        send_word(OP_PUSH, 64'h8000_0000_0000_0000);
        send_word(OP_PUSH, '1);
        send_word(OP_DIV, '0);        // most negative / -1 wraps
        send_word(OP_PUSH, '0);
        send_word(OP_DIV, '0);        // divide by zero
        send_word(OP_PUSH, 64'h7fff_ffff_ffff_ffff);
        send_word(OP_PUSH, 64'd5);
        send_word(OP_PICK, '0);       // index out of range
        send_word(OP_PUSH, '1);
        send_word(OP_PICK, '0);       // negative index
        send_word(OP_PUSH, 64'd1);
        send_word(OP_PICK, '0);
        for (op = OP_ADD; op <= OP_POP; op++) begin
            send_word(OP_PUSH, rand_cell());
            send_word(op, '0);
        end
        send_word(5'd27, '1);         // unused code
        send_word(5'd31, '0);
    endtask

    task automatic test_overflow();
        // Fill past full; hold the receiver off so the input stalls too.
        hold_cycles = 300;
        repeat (DEPTH + 4) send_word(OP_PUSH, rand_cell());
        send_word(OP_DUP, '0);
        send_word(OP_OVER, '0);
        send_word(OP_PICK, '0);
        repeat (DEPTH + 2) send_word(OP_POP, '0);
    endtask

    task automatic test_random(input int n);
        int         k;
        logic [4:0] op;
        for (k = 0; k < n; k++) begin
            if (k > n - 150) idle_enable = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2: op = (cell_count > 56) ? OP_POP : OP_PUSH;
                3: op = 5'($urandom_range(27, 31));
                4: begin
                    op = OP_PUSH;
                    send_word(op, 64'($urandom_range(0, cell_count)));
                    op = OP_PICK;
                end
                default: op = 5'($urandom_range(1, 26));
            endcase
            send_word(op, rand_cell());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_random(1230);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_total == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end

    initial begin
        #10000000;
        $display("tb: done, errors");
        $finish;
    end
endmodule
